@@ hw/rtl/psec_pkg.sv @@
`default_nettype none

package psec_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 4;

    // operation codes passed from front to back
    localparam int OP_KIND_W = 2;
    typedef logic [OP_KIND_W-1:0] op_kind_t;
    localparam op_kind_t OP_VERT  = 2'd0;
    localparam op_kind_t OP_CROSS = 2'd1;
    localparam op_kind_t OP_END   = 2'd2;

    // clip side codes
    typedef logic [1:0] side_t;
    localparam side_t SIDE_Y_BELOW = 2'd0;
    localparam side_t SIDE_Y_ABOVE = 2'd1;
    localparam side_t SIDE_X_ABOVE = 2'd2;
    localparam side_t SIDE_X_BELOW = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_SIDE = 1'd0;
    localparam cfg_idx_t CFG_LINE = 1'd1;

    function automatic logic side_is_y_axis(input side_t side);
        return (side == SIDE_Y_BELOW) || (side == SIDE_Y_ABOVE);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/psec_if.sv @@
`default_nettype none

interface psec_vert_if #(parameter int COORD_BITS = psec_pkg::COORD_BITS_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vert_x;
    logic signed [COORD_BITS-1:0] vert_y;
    logic signed [COORD_BITS-1:0] vert_z;
    logic                         last_vertex;

    modport source (output valid, vert_x, vert_y, vert_z, last_vertex, input ready);
    modport sink (input valid, vert_x, vert_y, vert_z, last_vertex, output ready);
endinterface

interface psec_res_if #(parameter int COORD_BITS = psec_pkg::COORD_BITS_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic                         last_out;
    logic                         all_clipped;

    modport source (output valid, out_x, out_y, out_z, last_out, all_clipped, input ready);
    modport sink (input valid, out_x, out_y, out_z, last_out, all_clipped, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/psec_queue.sv @@
`default_nettype none

module psec_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = psec_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic [WIDTH-1:0]      rd_data
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/psec_front.sv @@
`default_nettype none

module psec_front #(
    parameter int COORD_BITS = psec_pkg::COORD_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire psec_pkg::side_t                       side,
    input  wire logic signed [COORD_BITS-1:0]          line,
    psec_vert_if.sink                                  vert,
    output logic                                       op_valid,
    input  wire logic                                  op_ready,
    output logic [psec_pkg::OP_KIND_W+5*COORD_BITS-1:0] op_data
);
    import psec_pkg::*;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_E1A  = 3'd1;
    localparam logic [2:0] F_E1B  = 3'd2;
    localparam logic [2:0] F_E2A  = 3'd3;
    localparam logic [2:0] F_E2B  = 3'd4;
    localparam logic [2:0] F_END  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       have_first_reg, have_first_next;
    logic       kept_last_reg, kept_last_next;
    logic       has_edge_reg, has_edge_next;
    logic       cur_last_reg, cur_last_next;

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_y_reg, cur_z_reg;
    logic signed [COORD_BITS-1:0] first_x_reg, first_y_reg, first_z_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg, prev_z_reg;

    logic                         accept;
    logic                         sel_e2;
    logic                         slot_a;
    logic                         slot_b;
    logic                         edge_on;
    logic                         axis_y;
    logic                         keep_low;
    logic signed [COORD_BITS-1:0] p_x, p_y, p_z, q_x, q_y, q_z;
    logic signed [COORD_BITS-1:0] a1, a2;
    logic                         crosses;
    logic                         k1;
    logic                         want_a;
    logic                         want_b;
    logic                         advance;
    op_kind_t                     op_kind;
    logic signed [COORD_BITS-1:0] v_x, v_y, v_z;

    assign vert.ready = (state_reg == F_IDLE);
    assign accept     = vert.valid && vert.ready;

    // first edge runs prev->cur, closing edge runs cur->first
    assign sel_e2  = (state_reg == F_E2A) || (state_reg == F_E2B);
    assign slot_a  = (state_reg == F_E1A) || (state_reg == F_E2A);
    assign slot_b  = (state_reg == F_E1B) || (state_reg == F_E2B);
    assign edge_on = sel_e2 || has_edge_reg;

    assign p_x = sel_e2 ? cur_x_reg : prev_x_reg;
    assign p_y = sel_e2 ? cur_y_reg : prev_y_reg;
    assign p_z = sel_e2 ? cur_z_reg : prev_z_reg;
    assign q_x = sel_e2 ? first_x_reg : cur_x_reg;
    assign q_y = sel_e2 ? first_y_reg : cur_y_reg;
    assign q_z = sel_e2 ? first_z_reg : cur_z_reg;

    assign axis_y   = side_is_y_axis(side);
    assign keep_low = (side == SIDE_Y_BELOW) || (side == SIDE_X_BELOW);
    assign a1       = axis_y ? p_y : p_x;
    assign a2       = axis_y ? q_y : q_x;
    assign crosses  = !(((a1 < line) && (a2 < line)) || ((a1 > line) && (a2 > line)));
    assign k1       = keep_low ? (a1 < line) : (a1 > line);

    // slot a: kept start or crossing of an entering edge
    assign want_a = edge_on && ((k1 && !kept_last_reg) || (crosses && !k1));
    // slot b: end vertex or crossing of a leaving edge; closing edge drops its end
    assign want_b = edge_on && ((k1 && crosses) || ((k1 ^ crosses) && !sel_e2));

    always_comb
    begin
        op_valid = 1'b0;
        op_kind  = OP_VERT;
        v_x      = p_x;
        v_y      = p_y;
        v_z      = p_z;
        if (slot_a)
        begin
            op_valid = want_a;
            op_kind  = k1 ? OP_VERT : OP_CROSS;
        end
        else if (slot_b)
        begin
            op_valid = want_b;
            if (!(k1 && crosses))
            begin
                v_x = q_x;
                v_y = q_y;
                v_z = q_z;
            end
            else
            begin
                op_kind = OP_CROSS;
            end
        end
        else if (state_reg == F_END)
        begin
            op_valid = 1'b1;
            op_kind  = OP_END;
        end
    end

    assign op_data = {op_kind, v_x, v_y, v_z, q_x, q_y};
    assign advance = !op_valid || op_ready;

    always_comb
    begin
        state_next      = state_reg;
        have_first_next = have_first_reg;
        kept_last_next  = kept_last_reg;
        has_edge_next   = has_edge_reg;
        cur_last_next   = cur_last_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    cur_last_next   = vert.last_vertex;
                    has_edge_next   = have_first_reg;
                    have_first_next = 1'b1;
                    state_next      = F_E1A;
                end
            end
            F_E1A:
            begin
                if (advance)
                begin
                    state_next = F_E1B;
                end
            end
            F_E1B:
            begin
                if (advance)
                begin
                    if (has_edge_reg)
                    begin
                        kept_last_next = k1 ^ crosses;
                    end
                    state_next = cur_last_reg ? F_E2A : F_IDLE;
                end
            end
            F_E2A:
            begin
                if (advance)
                begin
                    state_next = F_E2B;
                end
            end
            F_E2B:
            begin
                if (advance)
                begin
                    state_next = F_END;
                end
            end
            F_END:
            begin
                if (op_ready)
                begin
                    have_first_next = 1'b0;
                    kept_last_next  = 1'b0;
                    state_next      = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            have_first_reg <= 1'b0;
            kept_last_reg  <= 1'b0;
            has_edge_reg   <= 1'b0;
            cur_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            have_first_reg <= have_first_next;
            kept_last_reg  <= kept_last_next;
            has_edge_reg   <= has_edge_next;
            cur_last_reg   <= cur_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_x_reg <= vert.vert_x;
            cur_y_reg <= vert.vert_y;
            cur_z_reg <= vert.vert_z;
        end
        if (accept && !have_first_reg)
        begin
            first_x_reg <= vert.vert_x;
            first_y_reg <= vert.vert_y;
            first_z_reg <= vert.vert_z;
        end
        if ((state_reg == F_E1B) && advance)
        begin
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
            prev_z_reg <= cur_z_reg;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/psec_back.sv @@
`default_nettype none

module psec_back #(
    parameter int COORD_BITS = psec_pkg::COORD_BITS_DEF
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire psec_pkg::side_t                            side,
    input  wire logic signed [COORD_BITS-1:0]               line,
    input  wire logic                                       op_valid,
    output logic                                            op_ready,
    input  wire logic [psec_pkg::OP_KIND_W+5*COORD_BITS-1:0] op_data,
    psec_res_if.source                                      res
);
    import psec_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int CNT_W = $clog2(COORD_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(COORD_BITS);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_MUL  = 3'd1;
    localparam logic [2:0] B_DIV  = 3'd2;
    localparam logic [2:0] B_FIX  = 3'd3;
    localparam logic [2:0] B_PUSH = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic             held_valid_reg, held_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic signed [C-1:0] held_x_reg, held_y_reg, held_z_reg;
    logic signed [C-1:0] cand_x_reg, cand_y_reg, cand_z_reg;
    logic signed [C-1:0] w1_reg;
    logic                neg_reg;
    logic [C:0]          mdw_reg, mdb_reg, mda_reg;
    logic [C:0]          rem_reg;
    logic [C:0]          quo_reg;
    logic signed [C-1:0] ox_reg, oy_reg, oz_reg;
    logic                olast_reg, oall_reg;

    op_kind_t            op_kind;
    logic signed [C-1:0] px, py, pz, qx, qy;
    logic                axis_y;
    logic signed [C-1:0] a1, a2, w1, w2;
    logic [C:0]          dw, db, da;
    logic [2*C+1:0]      prod;
    logic [C+1:0]        rem_sh;
    logic [C+1:0]        d_ext;
    logic [C+1:0]        rem_sub;
    logic                ge;
    logic [C+1:0]        wsum;

    logic                out_free;
    logic                pop;
    logic                load_cross;
    logic                load_held;
    logic                sel_cand;
    logic                emit;
    logic                emit_last;
    logic                emit_all;
    logic signed [C-1:0] emit_x, emit_y, emit_z;

    assign op_kind = op_data[OP_KIND_W+5*C-1 -: OP_KIND_W];
    assign px      = op_data[5*C-1 -: C];
    assign py      = op_data[4*C-1 -: C];
    assign pz      = op_data[3*C-1 -: C];
    assign qx      = op_data[2*C-1 -: C];
    assign qy      = op_data[C-1:0];

    assign axis_y = side_is_y_axis(side);
    assign a1     = axis_y ? py : px;
    assign a2     = axis_y ? qy : qx;
    assign w1     = axis_y ? px : py;
    assign w2     = axis_y ? qx : qy;

    assign dw = {w2[C-1], w2} - {w1[C-1], w1};
    assign db = {line[C-1], line} - {a1[C-1], a1};
    assign da = {a2[C-1], a2} - {a1[C-1], a1};

    assign prod = mdw_reg * mdb_reg;

    // restoring divide step, quotient bits shift into the low word
    assign rem_sh  = {rem_reg, quo_reg[C]};
    assign d_ext   = {1'b0, mda_reg};
    assign ge      = (rem_sh >= d_ext);
    assign rem_sub = rem_sh - d_ext;

    assign wsum = neg_reg ? ({{2{w1_reg[C-1]}}, w1_reg} - {1'b0, quo_reg})
                          : ({{2{w1_reg[C-1]}}, w1_reg} + {1'b0, quo_reg});

    assign out_free = !out_valid_reg || res.ready;
    assign sel_cand = (state_reg == B_PUSH);

    always_comb
    begin
        state_next      = state_reg;
        held_valid_next = held_valid_reg;
        cnt_next        = cnt_reg;
        pop             = 1'b0;
        load_cross      = 1'b0;
        load_held       = 1'b0;
        emit            = 1'b0;
        emit_last       = 1'b0;
        emit_all        = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (op_valid)
                begin
                    unique case (op_kind)
                        OP_VERT:
                        begin
                            if (!held_valid_reg || out_free)
                            begin
                                pop       = 1'b1;
                                emit      = held_valid_reg;
                                load_held = 1'b1;
                            end
                        end
                        OP_END:
                        begin
                            if (out_free)
                            begin
                                pop             = 1'b1;
                                emit            = 1'b1;
                                emit_last       = 1'b1;
                                emit_all        = !held_valid_reg;
                                held_valid_next = 1'b0;
                            end
                        end
                        OP_CROSS:
                        begin
                            pop        = 1'b1;
                            load_cross = 1'b1;
                            // an edge lying along the line crosses at its start
                            state_next = (a1 == a2) ? B_PUSH : B_MUL;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            B_MUL:
            begin
                cnt_next   = '0;
                state_next = B_DIV;
            end
            B_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = B_FIX;
                end
            end
            B_FIX:
            begin
                state_next = B_PUSH;
            end
            B_PUSH:
            begin
                if (!held_valid_reg || out_free)
                begin
                    emit       = held_valid_reg;
                    load_held  = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
        if (load_held)
        begin
            held_valid_next = 1'b1;
        end
    end

    assign op_ready = pop;

    assign emit_x = emit_all ? '0 : held_x_reg;
    assign emit_y = emit_all ? '0 : held_y_reg;
    assign emit_z = emit_all ? '0 : held_z_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_cross)
        begin
            w1_reg     <= w1;
            neg_reg    <= dw[C] ^ db[C] ^ da[C];
            mdw_reg    <= dw[C] ? (~dw + 1'b1) : dw;
            mdb_reg    <= db[C] ? (~db + 1'b1) : db;
            mda_reg    <= da[C] ? (~da + 1'b1) : da;
            cand_x_reg <= axis_y ? w1 : line;
            cand_y_reg <= axis_y ? line : w1;
            cand_z_reg <= '0;
        end
        if (state_reg == B_MUL)
        begin
            rem_reg <= prod[2*C+1:C+1];
            quo_reg <= prod[C:0];
        end
        if (state_reg == B_DIV)
        begin
            rem_reg <= ge ? rem_sub[C:0] : rem_sh[C:0];
            quo_reg <= {quo_reg[C-1:0], ge};
        end
        if (state_reg == B_FIX)
        begin
            if (axis_y)
            begin
                cand_x_reg <= wsum[C-1:0];
            end
            else
            begin
                cand_y_reg <= wsum[C-1:0];
            end
        end
        if (load_held)
        begin
            held_x_reg <= sel_cand ? cand_x_reg : px;
            held_y_reg <= sel_cand ? cand_y_reg : py;
            held_z_reg <= sel_cand ? cand_z_reg : pz;
        end
        if (emit)
        begin
            ox_reg    <= emit_x;
            oy_reg    <= emit_y;
            oz_reg    <= emit_z;
            olast_reg <= emit_last;
            oall_reg  <= emit_all;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.out_x       = ox_reg;
    assign res.out_y       = oy_reg;
    assign res.out_z       = oz_reg;
    assign res.last_out    = olast_reg;
    assign res.all_clipped = oall_reg;

endmodule

`default_nettype wire

@@ hw/rtl/polygon_single_edge_clipper.sv @@
// the front steps a vertex through states E1A and E1B, a closing vertex also through
// E2A, E2B and END; the back takes a kept vertex in IDLE and builds a crossing point
// in MUL, DIV (restoring radix-2 divide of COORD_BITS+1 quotient bits), FIX and PUSH.
// results trail by one emitted vertex so the final one can carry last_out.
// reset: clears the polygon state, the op queue, the held vertex and both config
// registers (side 0, line 0).
`default_nettype none

module polygon_single_edge_clipper #(
    parameter int COORD_BITS = psec_pkg::COORD_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    psec_vert_if.sink                      vert,
    psec_res_if.source                     res,
    input  wire logic                      cfg_we,
    input  wire psec_pkg::cfg_idx_t        cfg_index,
    input  wire logic [COORD_BITS-1:0]     cfg_data
);
    import psec_pkg::*;

    localparam int OP_W = OP_KIND_W + 5 * COORD_BITS;

    side_t                        side_reg, side_next;
    logic signed [COORD_BITS-1:0] line_reg, line_next;

    logic            fq_valid, fq_ready;
    logic [OP_W-1:0] fq_data;
    logic            qb_valid, qb_ready;
    logic [OP_W-1:0] qb_data;

    always_comb
    begin
        side_next = side_reg;
        line_next = line_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SIDE: side_next = cfg_data[1:0];
                CFG_LINE: line_next = cfg_data;
                default:  side_next = side_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_Y_BELOW;
            line_reg <= '0;
        end
        else
        begin
            side_reg <= side_next;
            line_reg <= line_next;
        end
    end

    psec_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .side     (side_reg),
        .line     (line_reg),
        .vert     (vert),
        .op_valid (fq_valid),
        .op_ready (fq_ready),
        .op_data  (fq_data)
    );

    psec_queue #(
        .WIDTH(OP_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    psec_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .side     (side_reg),
        .line     (line_reg),
        .op_valid (qb_valid),
        .op_ready (qb_ready),
        .op_data  (qb_data),
        .res      (res)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_polygon_single_edge_clipper.sv @@
`timescale 1ns / 100ps

module tb_polygon_single_edge_clipper;
    import psec_pkg::*;

    localparam int CB             = 16;
    localparam int MAX_OUTS       = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int RANDOM_ITEMS   = 190;
    localparam int RANDOM_PHASES  = 10;

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
    } vtx_t;

    typedef struct packed {
        vtx_t v;
        logic last;
        logic all_clipped;
    } clip_out_t;

    class clip_scoreboard;
        side_t                side;
        logic signed [CB-1:0] line;
        vtx_t                 first_v;
        vtx_t                 prev_v;
        vtx_t                 held;
        bit                   have_first;
        bit                   kept_last;
        bit                   any_emitted;
        vtx_t                 emit_list[$];
        clip_out_t            expected_outs[$];
        int                   errors;

        function new();
            side        = SIDE_Y_BELOW;
            line        = '0;
            first_v     = '0;
            prev_v      = '0;
            held        = '0;
            have_first  = 1'b0;
            kept_last   = 1'b0;
            any_emitted = 1'b0;
            errors      = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CB-1:0] data);
            if (idx == CFG_SIDE)
                side = side_t'(data[1:0]);
            else
                line = data;
        endfunction

        function int pending();
            return expected_outs.size();
        endfunction

        function bit y_axis();
            return (side == SIDE_Y_BELOW) || (side == SIDE_Y_ABOVE);
        endfunction

        function longint axis_of(vtx_t p);
            return y_axis() ? longint'($signed(p.y)) : longint'($signed(p.x));
        endfunction

        function longint other_of(vtx_t p);
            return y_axis() ? longint'($signed(p.x)) : longint'($signed(p.y));
        endfunction

        function bit kept(longint a, longint b);
            if (side == SIDE_Y_BELOW || side == SIDE_X_BELOW)
                return a < b;
            return a > b;
        endfunction

        function void push_vtx(vtx_t p);
            emit_list.insert(emit_list.size(), p);
            any_emitted = 1'b1;
        endfunction

        function vtx_t cross_point(vtx_t p, vtx_t q, longint b);
            longint a1;
            longint a2;
            longint w1;
            longint w2;
            longint w;
            vtx_t   c;
            a1 = axis_of(p);
            a2 = axis_of(q);
            w1 = other_of(p);
            w2 = other_of(q);
            w  = w1;
            // edge lying on the line keeps the start coordinate
            if (a1 != a2)
                w = w1 + ((w2 - w1) * (b - a1)) / (a2 - a1);
            if (y_axis())
            begin
                c.x = w[CB-1:0];
                c.y = b[CB-1:0];
            end
            else
            begin
                c.x = b[CB-1:0];
                c.y = w[CB-1:0];
            end
            c.z = '0;
            return c;
        endfunction

        function void clip_edge(vtx_t p, vtx_t q);
            longint b;
            longint a1;
            longint a2;
            bit     crosses;
            bit     start_kept;
            b          = longint'(line);
            a1         = axis_of(p);
            a2         = axis_of(q);
            crosses    = !((a1 < b && a2 < b) || (a1 > b && a2 > b));
            start_kept = kept(a1, b);
            if (!crosses)
            begin
                if (start_kept)
                begin
                    if (!kept_last)
                        push_vtx(p);
                    push_vtx(q);
                    kept_last = 1'b1;
                end
                else
                    kept_last = 1'b0;
            end
            else if (start_kept)
            begin
                if (!kept_last)
                    push_vtx(p);
                push_vtx(cross_point(p, q, b));
                kept_last = 1'b0;
            end
            else
            begin
                // end vertex goes out even when it sits on the line
                push_vtx(cross_point(p, q, b));
                push_vtx(q);
                kept_last = 1'b1;
            end
        endfunction

        function void note_vertex(vtx_t v, bit last);
            int n;
            emit_list.delete();
            if (any_emitted)
                emit_list.insert(emit_list.size(), held);
            if (!have_first)
            begin
                first_v    = v;
                have_first = 1'b1;
            end
            else
                clip_edge(prev_v, v);
            prev_v = v;
            if (!last)
            begin
                // newest vertex stays held back so the final one can carry last_out
                for (int i = 0; i + 1 < emit_list.size(); i++)
                    expected_outs.insert(expected_outs.size(),
                                         clip_out_t'{emit_list[i], 1'b0, 1'b0});
                if (emit_list.size() > 0)
                    held = emit_list[emit_list.size() - 1];
                return;
            end
            clip_edge(v, first_v);
            // closing in the kept state repeats the first vertex
            if (kept_last && emit_list.size() > 0)
                emit_list.delete(emit_list.size() - 1);
            n = emit_list.size();
            if (n == 0)
                expected_outs.insert(expected_outs.size(), clip_out_t'{'0, 1'b1, 1'b1});
            else
                for (int i = 0; i < n && i < MAX_OUTS; i++)
                    expected_outs.insert(expected_outs.size(),
                                         clip_out_t'{emit_list[i], i == n - 1, 1'b0});
            have_first  = 1'b0;
            kept_last   = 1'b0;
            any_emitted = 1'b0;
        endfunction

        function void check_result(clip_out_t got);
            clip_out_t want;
            if (expected_outs.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output vertex: x=%0d y=%0d z=%0d %s=%0b %s=%0b",
                             $signed(got.v.x), $signed(got.v.y), $signed(got.v.z),
                             "last", got.last, "all_clipped", got.all_clipped);
                return;
            end
            want = expected_outs.pop_front();
            if (got.v.x !== want.v.x || got.v.y !== want.v.y || got.v.z !== want.v.z ||
                got.last !== want.last || got.all_clipped !== want.all_clipped)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch: expected x=%0d y=%0d z=%0d last=%0b all_clipped=%0b",
                             $signed(want.v.x), $signed(want.v.y), $signed(want.v.z),
                             want.last, want.all_clipped);
                    $display("          got      x=%0d y=%0d z=%0d last=%0b all_clipped=%0b",
                             $signed(got.v.x), $signed(got.v.y), $signed(got.v.z),
                             got.last, got.all_clipped);
                end
            end
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n;
    logic           cfg_we;
    cfg_idx_t       cfg_index;
    logic [CB-1:0]  cfg_data;

    psec_vert_if #(.COORD_BITS(CB)) vert_bus ();
    psec_res_if  #(.COORD_BITS(CB)) res_bus ();

    clip_scoreboard sb;
    bit  idle_on;
    int  stall_left = 0;
    int  idle_cycles = 0;
    int  vertex_count = 0;
    int  result_count = 0;
    int  polygon_count;
    int  setting_count;

    polygon_single_edge_clipper #(.COORD_BITS(CB)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vert      (vert_bus),
        .res       (res_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver drops ready at random while idle_on is set
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            res_bus.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 8);
            res_bus.ready <= 1'b0;
        end
        else
            res_bus.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (vert_bus.valid && vert_bus.ready)
            begin
                sb.note_vertex(vtx_t'{vert_bus.vert_x, vert_bus.vert_y, vert_bus.vert_z},
                               vert_bus.last_vertex);
                vertex_count++;
            end
            if (res_bus.valid && res_bus.ready)
            begin
                sb.check_result(clip_out_t'{
                    vtx_t'{res_bus.out_x, res_bus.out_y, res_bus.out_z},
                    res_bus.last_out, res_bus.all_clipped});
                result_count++;
            end
            if ((vert_bus.valid && vert_bus.ready) || (res_bus.valid && res_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send_vertex(input int x, input int y, input int z, input bit last);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 9);
        if (gap > 0)
        begin
            vert_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vert_bus.valid       <= 1'b1;
        vert_bus.vert_x      <= x[CB-1:0];
        vert_bus.vert_y      <= y[CB-1:0];
        vert_bus.vert_z      <= z[CB-1:0];
        vert_bus.last_vertex <= last;
        @(posedge clk);
        while (!vert_bus.ready) @(posedge clk);
        if (last)
            polygon_count++;
    endtask

    // hold off the sender until every output vertex is in, then let the block settle
    task automatic drain();
        vert_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_clip(input side_t s, input int line_val);
        logic [CB-1:0] side_word;
        side_word      = CB'($urandom);
        side_word[1:0] = s;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SIDE;
        cfg_data  <= side_word;
        @(posedge clk);
        sb.set_reg(CFG_SIDE, side_word);
        cfg_index <= CFG_LINE;
        cfg_data  <= line_val[CB-1:0];
        @(posedge clk);
        sb.set_reg(CFG_LINE, line_val[CB-1:0]);
        cfg_we <= 1'b0;
        setting_count++;
    endtask

    function automatic int pick_coord(input int center);
        int v;
        case ($urandom_range(0, 15))
            0, 1, 2: v = int'($urandom_range(0, 65535)) - 32768;
            3:       v = center;
            4:       v = ($urandom_range(0, 1) == 0) ? -32768 : 32767;
            default: v = center + int'($urandom_range(0, 400)) - 200;
        endcase
        if (v < -32768)
            v = -32768;
        if (v > 32767)
            v = 32767;
        return v;
    endfunction

    task automatic send_random_polygon(input side_t s, input int line_val, inout int left);
        int n;
        int a;
        int w;
        int z;
        n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 6);
        for (int i = 0; i < n; i++)
        begin
            a = pick_coord(line_val);
            w = pick_coord(0);
            z = int'($urandom_range(0, 65535)) - 32768;
            if (s == SIDE_Y_BELOW || s == SIDE_Y_ABOVE)
                send_vertex(w, a, z, i == n - 1);
            else
                send_vertex(a, w, z, i == n - 1);
            left--;
        end
    endtask

    initial
    begin
        side_t s;
        int    line_val;
        int    left;
        sb                   = new();
        idle_on              = 1'b1;
        polygon_count        = 0;
        setting_count        = 0;
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= CFG_SIDE;
        cfg_data             <= '0;
        vert_bus.valid       <= 1'b0;
        vert_bus.vert_x      <= '0;
        vert_bus.vert_y      <= '0;
        vert_bus.vert_z      <= '0;
        vert_bus.last_vertex <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: keep below y = 0
        set_clip(SIDE_Y_BELOW, 0);
        send_vertex(-100, -50, 7, 1'b0);
        send_vertex(100, 50, -8, 1'b0);
        send_vertex(0, -80, 9, 1'b1);
        // nothing survives
        send_vertex(10, 20, 1, 1'b0);
        send_vertex(30, 40, 2, 1'b0);
        send_vertex(50, 60, 3, 1'b1);
        // single vertex, kept and then on the line
        send_vertex(5, -5, 3, 1'b1);
        send_vertex(7, 0, 4, 1'b1);
        // horizontal edge lying on the line
        send_vertex(-10, 0, 1, 1'b0);
        send_vertex(10, 0, 2, 1'b0);
        send_vertex(0, -10, 3, 1'b1);
        send_vertex(-32768, -32768, -32768, 1'b0);
        send_vertex(32767, 32767, 32767, 1'b0);
        send_vertex(32767, -32768, 0, 1'b1);
        drain();
        set_clip(SIDE_X_ABOVE, 32767);
        send_vertex(32767, 5, 1, 1'b0);
        send_vertex(-32768, -32768, -1, 1'b0);
        send_vertex(32767, 32767, 2, 1'b1);
        drain();
        set_clip(SIDE_X_BELOW, -32768);
        send_vertex(-32768, 100, 5, 1'b0);
        send_vertex(0, 0, 0, 1'b0);
        send_vertex(-32768, -100, -5, 1'b1);
        drain();
        set_clip(SIDE_Y_ABOVE, -32768);
        send_vertex(0, 32767, 1, 1'b0);
        send_vertex(100, -32768, 2, 1'b0);
        send_vertex(-100, 0, 3, 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            if (p < 4)
                s = side_t'(p);
            else
                s = side_t'($urandom_range(0, 3));
            case (p)
                0:       line_val = -32768;
                1:       line_val = 32767;
                2:       line_val = 0;
                3:       line_val = int'($urandom_range(0, 65535)) - 32768;
                default: line_val = int'($urandom_range(0, 2000)) - 1000;
            endcase
            if (p == RANDOM_PHASES - 1)
                idle_on = 1'b0;
            set_clip(s, line_val);
            left = RANDOM_ITEMS / RANDOM_PHASES;
            while (left > 0)
                send_random_polygon(s, line_val, left);
        end
        drain();

        $display("run covered %0d vertices in %0d polygons over %0d clip settings",
                 vertex_count, polygon_count, setting_count);
        $display("%0d output vertices checked, %0d errors", result_count, sb.errors);
        if (sb.pending() != 0)
        begin
            $display("%0d expected output vertices never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ polygon_single_edge_clipper.f @@
hw/rtl/psec_pkg.sv
hw/rtl/psec_if.sv
hw/rtl/psec_queue.sv
hw/rtl/psec_front.sv
hw/rtl/psec_back.sv
hw/rtl/polygon_single_edge_clipper.sv
tb/sv/tb_polygon_single_edge_clipper.sv
